### design/klex_pkg.sv
// Package for the keyword lexer: token kinds, modes, controller states,
// keyword and symbol tables, and the command and status structs.
// Used by every module of the design; depends on nothing.
`default_nettype none

package klex_pkg;

    localparam int WORD_MAX_DEF  = 32;
    localparam int LINE_BITS_DEF = 16;
    localparam int MAX_RESULTS   = 34;
    localparam int NUM_KW        = 17;

    localparam logic [5:0] KIND_SYM0  = 6'd17;
    localparam logic [5:0] KIND_NL    = 6'd22;
    localparam logic [5:0] KIND_IDENT = 6'd32;
    localparam logic [5:0] KIND_ERROR = 6'd33;
    localparam logic [5:0] KIND_END   = 6'd34;

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_CHAR = 2'd1;
    localparam logic [1:0] ERR_LONG = 2'd2;

    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_DASH  = 8'd45;
    localparam logic [7:0] CH_OPEN  = 8'd91;
    localparam logic [7:0] CH_CLOSE = 8'd93;

    typedef enum logic [1:0] {
        MODE_SYMBOL,
        MODE_WORD,
        MODE_LINE,
        MODE_BLOCK
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_KW,
        ST_IDRD,
        ST_IDENT,
        ST_TOK,
        ST_END
    } state_t;

    typedef enum logic [1:0] {
        SEL_KW,
        SEL_IDENT,
        SEL_TOK,
        SEL_END
    } emit_sel_t;

    typedef struct packed {
        logic      accept;
        logic      rd_start;
        logic      rd_next;
        logic      emit;
        emit_sel_t sel;
        logic      last;
    } cmd_t;

    typedef struct packed {
        logic fin;
        logic kw_hit;
        logic tok;
        logic fin_end;
        logic id_last;
        logic out_free;
    } stat_t;

    // Keyword text, left-aligned in seven characters.
    function automatic logic [55:0] kw_str(input logic [4:0] k);
        case (k)
            5'd0:    kw_str = "IF     ";
            5'd1:    kw_str = "POW    ";
            5'd2:    kw_str = "EMPTY? ";
            5'd3:    kw_str = "NULL?  ";
            5'd4:    kw_str = "EQ     ";
            5'd5:    kw_str = "NEQ    ";
            5'd6:    kw_str = "TAKE   ";
            5'd7:    kw_str = "PUT    ";
            5'd8:    kw_str = "PEEK   ";
            5'd9:    kw_str = "XOR    ";
            5'd10:   kw_str = "RETURN ";
            5'd11:   kw_str = "EXEC   ";
            5'd12:   kw_str = "OUTNUM ";
            5'd13:   kw_str = "OUTCHAR";
            5'd14:   kw_str = "OUT    ";
            5'd15:   kw_str = "STACK  ";
            5'd16:   kw_str = "APPLY  ";
            default: kw_str = "       ";
        endcase
    endfunction

    function automatic logic [2:0] kw_len(input logic [4:0] k);
        case (k)
            5'd0, 5'd4:                      kw_len = 3'd2;
            5'd1, 5'd5, 5'd7, 5'd9, 5'd14:   kw_len = 3'd3;
            5'd6, 5'd8, 5'd11:               kw_len = 3'd4;
            5'd3, 5'd15, 5'd16:              kw_len = 3'd5;
            5'd2, 5'd10, 5'd12:              kw_len = 3'd6;
            5'd13:                           kw_len = 3'd7;
            default:                         kw_len = 3'd0;
        endcase
    endfunction

    function automatic logic [7:0] kw_char(input logic [4:0] k, input logic [2:0] p);
        logic [55:0] s;
        s = kw_str(k);
        kw_char = (p == 3'd7) ? 8'd0 : s[55 - 8 * p -: 8];
    endfunction

    // Returns {hit, index} for the fifteen single-character symbols.
    function automatic logic [4:0] sym_code(input logic [7:0] c);
        case (c)
            8'd123:  sym_code = {1'b1, 4'd0};
            8'd125:  sym_code = {1'b1, 4'd1};
            8'd40:   sym_code = {1'b1, 4'd2};
            8'd41:   sym_code = {1'b1, 4'd3};
            8'd58:   sym_code = {1'b1, 4'd4};
            8'd10:   sym_code = {1'b1, 4'd5};
            8'd59:   sym_code = {1'b1, 4'd6};
            8'd91:   sym_code = {1'b1, 4'd7};
            8'd93:   sym_code = {1'b1, 4'd8};
            8'd36:   sym_code = {1'b1, 4'd9};
            8'd49:   sym_code = {1'b1, 4'd10};
            8'd48:   sym_code = {1'b1, 4'd11};
            8'd33:   sym_code = {1'b1, 4'd12};
            8'd38:   sym_code = {1'b1, 4'd13};
            8'd124:  sym_code = {1'b1, 4'd14};
            default: sym_code = 5'd0;
        endcase
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        is_letter = (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
    endfunction

    function automatic logic is_word_char(input logic [7:0] c);
        is_word_char = is_letter(c) || (c >= 8'd48 && c <= 8'd57)
                       || c == 8'd95 || c == 8'd63;
    endfunction

endpackage

`default_nettype wire

### design/klex_char_if.sv
// Character channel: valid, ready and one source character per word.
// Depends on nothing.
`default_nettype none

interface klex_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink (input valid, input ch, output ready);
endinterface

`default_nettype wire

### design/klex_tok_if.sv
// Token channel: valid, ready and the fields of one token per word.
// Depends on nothing.
`default_nettype none

interface klex_tok_if;
    logic        valid;
    logic        ready;
    logic [5:0]  kind;
    logic [15:0] line;
    logic [7:0]  ident_char;
    logic        ident_last;
    logic [1:0]  error_code;
    logic        last;

    modport source (output valid, output kind, output line, output ident_char,
                    output ident_last, output error_code, output last, input ready);
    modport sink (input valid, input kind, input line, input ident_char,
                  input ident_last, input error_code, input last, output ready);
endinterface

`default_nettype wire

### design/klex_ctrl.sv
// Controller of the keyword lexer: sequences the tokens of one character.
// Depends on klex_pkg.
`default_nettype none

module klex_ctrl
    import klex_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    state_t     state_reg, state_next;
    logic [5:0] rcnt_reg, rcnt_next;
    logic       cap;
    state_t     after_fin;
    state_t     after_tok;

    assign cap       = (rcnt_reg == 6'(MAX_RESULTS - 1));
    assign after_tok = stat.fin_end ? ST_END : ST_IDLE;
    assign after_fin = stat.tok ? ST_TOK : after_tok;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_START;
            end
            ST_START:
            begin
                if (stat.fin)
                    state_next = stat.kw_hit ? ST_KW : ST_IDRD;
                else
                    state_next = after_fin;
            end
            ST_KW:
            begin
                if (stat.out_free)
                    state_next = cap ? ST_IDLE : after_fin;
            end
            ST_IDRD:
                state_next = ST_IDENT;
            ST_IDENT:
            begin
                if (stat.out_free && cap)
                    state_next = ST_IDLE;
                else if (stat.out_free && stat.id_last)
                    state_next = after_fin;
            end
            ST_TOK:
            begin
                if (stat.out_free)
                    state_next = cap ? ST_IDLE : after_tok;
            end
            ST_END:
            begin
                if (stat.out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready     = (state_reg == ST_IDLE);
        cmd.accept   = in_valid && (state_reg == ST_IDLE);
        cmd.rd_start = 1'b0;
        cmd.rd_next  = 1'b0;
        cmd.emit     = 1'b0;
        cmd.sel      = SEL_TOK;
        cmd.last     = 1'b0;
        case (state_reg)
            ST_KW:
            begin
                cmd.emit = stat.out_free;
                cmd.sel  = SEL_KW;
                cmd.last = cap || (!stat.tok && !stat.fin_end);
            end
            ST_IDRD:
                cmd.rd_start = 1'b1;
            ST_IDENT:
            begin
                cmd.emit    = stat.out_free;
                cmd.sel     = SEL_IDENT;
                cmd.rd_next = stat.out_free && !stat.id_last;
                cmd.last    = cap || (stat.id_last && !stat.tok && !stat.fin_end);
            end
            ST_TOK:
            begin
                cmd.emit = stat.out_free;
                cmd.sel  = SEL_TOK;
                cmd.last = cap || !stat.fin_end;
            end
            ST_END:
            begin
                cmd.emit = stat.out_free;
                cmd.sel  = SEL_END;
                cmd.last = 1'b1;
            end
            default:
                cmd.emit = 1'b0;
        endcase
    end

    always_comb
    begin
        rcnt_next = rcnt_reg;
        if (cmd.accept)
            rcnt_next = 6'd0;
        else if (cmd.emit)
            rcnt_next = rcnt_reg + 6'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rcnt_reg  <= 6'd0;
        end
        else
        begin
            state_reg <= state_next;
            rcnt_reg  <= rcnt_next;
        end
    end

endmodule

`default_nettype wire

### design/klex_dpath.sv
// Datapath of the keyword lexer: scanner state, word store, keyword
// candidates, the token plan of one character and the output register.
// Depends on klex_pkg.
`default_nettype none

module klex_dpath
    import klex_pkg::*;
#(
    parameter int WORD_MAX  = WORD_MAX_DEF,
    parameter int LINE_BITS = LINE_BITS_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] ch,
    input  wire cmd_t       cmd,
    output stat_t           stat,
    input  wire logic       out_ready,
    output logic            out_valid,
    output logic [5:0]      out_kind,
    output logic [15:0]     out_line,
    output logic [7:0]      out_ident_char,
    output logic            out_ident_last,
    output logic [1:0]      out_error_code,
    output logic            out_last
);

    localparam int AW   = $clog2(WORD_MAX);
    localparam int LENW = $clog2(WORD_MAX + 1);
    localparam int LW   = (LINE_BITS > 16) ? LINE_BITS : 16;

    logic [7:0] mem [WORD_MAX];

    mode_t                 mode_reg, mode_next;
    logic                  skip_reg, skip_next;
    logic [7:0]            held_reg, held_next;
    logic                  held_valid_reg, held_valid_next;
    logic                  failed_reg, failed_next;
    logic [LENW-1:0]       wlen_reg, wlen_next;
    logic [NUM_KW-1:0]     cand_reg, cand_next;
    logic [LINE_BITS-1:0]  line_reg, line_next;

    logic                  fin_reg, fin_next;
    logic [LENW-1:0]       fin_len_reg, fin_len_next;
    logic                  kw_hit_reg, kw_hit_next;
    logic [4:0]            kw_idx_reg, kw_idx_next;
    logic                  tok_reg, tok_next;
    logic [5:0]            tok_kind_reg, tok_kind_next;
    logic [1:0]            tok_err_reg, tok_err_next;
    logic                  end_reg, end_next;
    logic [LINE_BITS-1:0]  tok_line_reg, tok_line_next;
    logic [LINE_BITS-1:0]  end_line_reg, end_line_next;

    logic [AW-1:0]         rd_idx_reg;
    logic [7:0]            rdata_reg;
    logic [AW-1:0]         rd_addr;

    logic                  out_valid_reg;
    logic [5:0]            out_kind_reg;
    logic [LINE_BITS-1:0]  out_line_reg;
    logic [7:0]            out_char_reg;
    logic                  out_ilast_reg;
    logic [1:0]            out_err_reg;
    logic                  out_last_reg;
    logic [LW-1:0]         line_ext;

    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [7:0]            wr_data;
    logic                  out_free;
    logic                  id_last;

    // Next scanner state and the token plan for one accepted character.
    always_comb
    begin
        logic                 nul;
        logic                 bump;
        logic [7:0]           c;
        logic [4:0]           sc;
        logic [NUM_KW-1:0]    fcand;
        logic                 sym_path;
        logic [LINE_BITS-1:0] line_inc;

        mode_next       = mode_reg;
        skip_next       = skip_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        failed_next     = failed_reg;
        wlen_next       = wlen_reg;
        cand_next       = cand_reg;
        line_next       = line_reg;
        fin_next        = 1'b0;
        fin_len_next    = wlen_reg;
        kw_hit_next     = 1'b0;
        kw_idx_next     = 5'd0;
        tok_next        = 1'b0;
        tok_kind_next   = KIND_ERROR;
        tok_err_next    = ERR_NONE;
        end_next        = 1'b0;
        tok_line_next   = line_reg;
        end_line_next   = line_reg;
        wr_en           = 1'b0;
        wr_addr         = wlen_reg[AW-1:0];
        wr_data         = held_reg;
        nul             = (ch == 8'd0);
        bump            = 1'b0;
        c               = held_reg;
        sc              = sym_code(held_reg);
        fcand           = cand_reg;
        sym_path        = 1'b0;
        line_inc        = (line_reg == '1) ? line_reg : line_reg + 1'b1;

        if (!failed_reg && held_valid_reg)
        begin
            if (skip_reg)
                skip_next = 1'b0;
            else if (c == CH_DASH && (ch == CH_DASH || ch == CH_OPEN))
                mode_next = (ch == CH_DASH) ? MODE_LINE : MODE_BLOCK;
            else
            begin
                case (mode_reg)
                    MODE_LINE:
                    begin
                        if (c == CH_NL)
                        begin
                            tok_next      = 1'b1;
                            tok_kind_next = KIND_NL;
                            bump          = 1'b1;
                            mode_next     = MODE_SYMBOL;
                        end
                    end
                    MODE_BLOCK:
                    begin
                        if (c == CH_NL)
                        begin
                            tok_next      = 1'b1;
                            tok_kind_next = KIND_NL;
                            bump          = 1'b1;
                        end
                        else if (c == CH_CLOSE && ch == CH_DASH)
                        begin
                            mode_next = MODE_SYMBOL;
                            skip_next = 1'b1;
                        end
                    end
                    MODE_WORD:
                    begin
                        if (is_word_char(c))
                        begin
                            if (wlen_reg >= LENW'(WORD_MAX))
                            begin
                                tok_next      = 1'b1;
                                tok_err_next  = ERR_LONG;
                                failed_next   = 1'b1;
                            end
                            else
                            begin
                                wr_en     = 1'b1;
                                wlen_next = wlen_reg + 1'b1;
                                for (int k = 0; k < NUM_KW; k++)
                                    cand_next[k] = cand_reg[k]
                                        && (wlen_reg < LENW'(kw_len(5'(k))))
                                        && (kw_char(5'(k), wlen_reg[2:0]) == c);
                            end
                        end
                        else
                        begin
                            fin_next     = 1'b1;
                            fin_len_next = wlen_reg;
                            fcand        = cand_reg;
                            wlen_next    = '0;
                            mode_next    = MODE_SYMBOL;
                            sym_path     = 1'b1;
                        end
                    end
                    default:
                        sym_path = 1'b1;
                endcase
                if (sym_path && !(c == CH_SPACE || c == CH_TAB))
                begin
                    if (sc[4])
                    begin
                        tok_next      = 1'b1;
                        tok_kind_next = KIND_SYM0 + 6'(sc[3:0]);
                        bump          = (c == CH_NL);
                    end
                    else if (is_letter(c))
                    begin
                        mode_next = MODE_WORD;
                        wr_en     = 1'b1;
                        wr_addr   = '0;
                        wlen_next = LENW'(1);
                        for (int k = 0; k < NUM_KW; k++)
                            cand_next[k] = (kw_char(5'(k), 3'd0) == c);
                    end
                    else
                    begin
                        tok_next     = 1'b1;
                        tok_err_next = ERR_CHAR;
                        failed_next  = 1'b1;
                    end
                end
            end
        end

        if (bump)
            line_next = line_inc;
        end_line_next = line_next;

        if (nul)
        begin
            if (!failed_next && mode_next == MODE_WORD)
            begin
                fin_next     = 1'b1;
                fin_len_next = wlen_next;
                fcand        = cand_next;
            end
            end_next        = 1'b1;
            mode_next       = MODE_SYMBOL;
            skip_next       = 1'b0;
            held_next       = 8'd0;
            held_valid_next = 1'b0;
            failed_next     = 1'b0;
            wlen_next       = '0;
            line_next       = '0;
        end
        else if (!failed_reg)
        begin
            held_next       = ch;
            held_valid_next = 1'b1;
        end

        for (int k = NUM_KW - 1; k >= 0; k--)
        begin
            if (fcand[k] && LENW'(kw_len(5'(k))) == fin_len_next)
            begin
                kw_hit_next = 1'b1;
                kw_idx_next = 5'(k);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_SYMBOL;
            skip_reg       <= 1'b0;
            held_reg       <= 8'd0;
            held_valid_reg <= 1'b0;
            failed_reg     <= 1'b0;
            wlen_reg       <= '0;
            line_reg       <= '0;
            fin_reg        <= 1'b0;
            tok_reg        <= 1'b0;
            end_reg        <= 1'b0;
        end
        else if (cmd.accept)
        begin
            mode_reg       <= mode_next;
            skip_reg       <= skip_next;
            held_reg       <= held_next;
            held_valid_reg <= held_valid_next;
            failed_reg     <= failed_next;
            wlen_reg       <= wlen_next;
            line_reg       <= line_next;
            fin_reg        <= fin_next;
            tok_reg        <= tok_next;
            end_reg        <= end_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cand_reg     <= cand_next;
            fin_len_reg  <= fin_len_next;
            kw_hit_reg   <= kw_hit_next;
            kw_idx_reg   <= kw_idx_next;
            tok_kind_reg <= tok_kind_next;
            tok_err_reg  <= tok_err_next;
            tok_line_reg <= tok_line_next;
            end_line_reg <= end_line_next;
        end
    end

    assign rd_addr = cmd.rd_start ? '0 : rd_idx_reg + 1'b1;

    always_ff @(posedge clk)
    begin
        if (cmd.accept && wr_en)
            mem[wr_addr] <= wr_data;
        if (cmd.rd_start || cmd.rd_next)
        begin
            rdata_reg  <= mem[rd_addr];
            rd_idx_reg <= rd_addr;
        end
    end

    assign id_last  = (LENW'(rd_idx_reg) + LENW'(1) == fin_len_reg);
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_last_reg  <= cmd.last;
            out_char_reg  <= 8'd0;
            out_ilast_reg <= 1'b0;
            out_err_reg   <= ERR_NONE;
            out_line_reg  <= tok_line_reg;
            case (cmd.sel)
                SEL_KW:
                    out_kind_reg <= {1'b0, kw_idx_reg};
                SEL_IDENT:
                begin
                    out_kind_reg  <= KIND_IDENT;
                    out_char_reg  <= rdata_reg;
                    out_ilast_reg <= id_last;
                end
                SEL_TOK:
                begin
                    out_kind_reg <= tok_kind_reg;
                    out_err_reg  <= tok_err_reg;
                end
                SEL_END:
                begin
                    out_kind_reg <= KIND_END;
                    out_line_reg <= end_line_reg;
                end
                default:
                    out_kind_reg <= KIND_END;
            endcase
        end
    end

    assign line_ext       = LW'(out_line_reg);
    assign out_valid      = out_valid_reg;
    assign out_kind       = out_kind_reg;
    assign out_line       = line_ext[15:0];
    assign out_ident_char = out_char_reg;
    assign out_ident_last = out_ilast_reg;
    assign out_error_code = out_err_reg;
    assign out_last       = out_last_reg;

    assign stat.fin      = fin_reg;
    assign stat.kw_hit   = kw_hit_reg;
    assign stat.tok      = tok_reg;
    assign stat.fin_end  = end_reg;
    assign stat.id_last  = id_last;
    assign stat.out_free = out_free;

endmodule

`default_nettype wire

### design/keyword_lexer.sv
// Top level of the keyword lexer: joins controller and datapath to the
// character and token channels. Depends on klex_pkg, klex_char_if,
// klex_tok_if, klex_ctrl and klex_dpath.
//
//   channel  direction  word
//   chars    in         one source character, NUL ends the text
//   tokens   out        kind, line, ident_char, ident_last, error_code, last
//
// A character word is taken in the idle state and its tokens follow the
// start state: each keyword, symbol or end token is emitted in turn, and
// an identifier one character at a time after a store read.
// The next character is taken once the last token sits in the output register.
// Reset clears the scanner to symbol mode at line zero; a stalled token
// channel holds the sequencer.
`default_nettype none

module keyword_lexer
    import klex_pkg::*;
#(
    parameter int WORD_MAX  = WORD_MAX_DEF,
    parameter int LINE_BITS = LINE_BITS_DEF
)
(
    input wire logic    clk,
    input wire logic    rst_n,
    klex_char_if.sink   chars,
    klex_tok_if.source  tokens
);

    cmd_t  cmd;
    stat_t stat;

    klex_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (chars.valid),
        .in_ready (chars.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    klex_dpath #(
        .WORD_MAX  (WORD_MAX),
        .LINE_BITS (LINE_BITS)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .ch             (chars.ch),
        .cmd            (cmd),
        .stat           (stat),
        .out_ready      (tokens.ready),
        .out_valid      (tokens.valid),
        .out_kind       (tokens.kind),
        .out_line       (tokens.line),
        .out_ident_char (tokens.ident_char),
        .out_ident_last (tokens.ident_last),
        .out_error_code (tokens.error_code),
        .out_last       (tokens.last)
    );

endmodule

`default_nettype wire
